/* hdl/gcps_pkg.sv */
// Package for the gravity compensated pitch solver.
// Field widths, register defaults, controller/datapath command and status types.
// Used by every other file of the block.
package gcps_pkg;

  localparam int DIST_W   = 15;
  localparam int HEIGHT_W = 15;
  localparam int SPEED_W  = 16;
  localparam int PITCH_W  = 18;
  localparam int ITER_W   = 4;

  localparam int GRAV_W   = 14;
  localparam int TOL_W    = 10;
  localparam int CFG_W    = 14;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd2;

  localparam logic [GRAV_W-1:0] GRAVITY_RST  = 14'd9789;
  localparam logic [TOL_W-1:0]  TOLERANCE_RST = 10'd10;
  localparam logic [ITER_W-1:0] MAX_ITER_RST = 4'd10;

  localparam int ANGLE_FRAC_BITS_DEF = 16;

  localparam logic [DIST_W-1:0]  DIST_MIN  = 15'd100;
  localparam logic [SPEED_W-1:0] SPEED_MIN = 16'd1000;

  localparam int AIM_W = 25;
  localparam logic signed [AIM_W-1:0] AIM_LIMIT = 25'sd16777215;

  localparam int MUL_STEPS = GRAV_W;
  localparam int DIV_STEPS = 44;
  localparam int COR_STEPS = 30;
  localparam int CNT_W     = 6;

  localparam int COR_PRESHIFT = 20;
  localparam int COR_W        = 48;
  localparam int ANG_W        = 33;

  typedef struct packed {
    logic [GRAV_W-1:0] gravity;
    logic [TOL_W-1:0]  tolerance;
    logic [ITER_W-1:0] max_iter;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             square;
    logic             mul_init;
    logic             mul_step;
    logic             div_init;
    logic             div_step;
    logic             update;
    logic             cor_init;
    logic             cor_step;
    logic             round;
    logic             emit;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic stop;
    logic zero_limit;
  } status_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
    logic [ANG_W-1:0] one;
    one = ANG_W'(1);
    case (i)
      5'd0:    atan_q30 = 33'sd843314857;
      5'd1:    atan_q30 = 33'sd497837829;
      5'd2:    atan_q30 = 33'sd263043837;
      5'd3:    atan_q30 = 33'sd133525159;
      5'd4:    atan_q30 = 33'sd67021687;
      5'd5:    atan_q30 = 33'sd33543516;
      5'd6:    atan_q30 = 33'sd16775851;
      5'd7:    atan_q30 = 33'sd8388437;
      5'd8:    atan_q30 = 33'sd4194283;
      5'd9:    atan_q30 = 33'sd2097149;
      default: atan_q30 = signed'(one << (5'd30 - i));
    endcase
  endfunction

endpackage

/* hdl/gcps_in_if.sv */
// Request channel of the pitch solver: valid/ready plus the request fields.
// Depends on gcps_pkg.
interface gcps_in_if import gcps_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [DIST_W-1:0]          distance_mm;
  logic signed [HEIGHT_W-1:0] height_mm;
  logic [SPEED_W-1:0]         speed_mm_s;

  modport source (output valid, distance_mm, height_mm, speed_mm_s, input ready);
  modport sink (input valid, distance_mm, height_mm, speed_mm_s, output ready);
endinterface

/* hdl/gcps_out_if.sv */
// Result channel of the pitch solver: valid/ready plus the result fields.
// Depends on gcps_pkg.
interface gcps_out_if import gcps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PITCH_W-1:0] pitch_angle;
  logic [ITER_W-1:0]         iterations_used;
  logic                      converged;

  modport source (output valid, pitch_angle, iterations_used, converged, input ready);
  modport sink (input valid, pitch_angle, iterations_used, converged, output ready);
endinterface

/* hdl/gcps_ctrl.sv */
// Sequencer of the pitch solver: steps the datapath through each pass and CORDIC.
// Depends on gcps_pkg.
module gcps_ctrl import gcps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQUARE, S_MINIT, S_MUL, S_DINIT, S_DIV, S_UPDATE, S_CHECK,
    S_CINIT, S_COR, S_ROUND, S_FIN
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             accept;
  logic             slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.idx      = cnt_q;
    cmd_o.load     = accept;
    cmd_o.square   = (state_q == S_SQUARE);
    cmd_o.mul_init = (state_q == S_MINIT);
    cmd_o.mul_step = (state_q == S_MUL);
    cmd_o.div_init = (state_q == S_DINIT);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.update   = (state_q == S_UPDATE);
    cmd_o.cor_init = (state_q == S_CINIT);
    cmd_o.cor_step = (state_q == S_COR);
    cmd_o.round    = (state_q == S_ROUND);
    cmd_o.emit     = (state_q == S_FIN) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) state_q <= status_i.zero_limit ? S_FIN : S_SQUARE;
        end
        S_SQUARE: state_q <= S_MINIT;
        S_MINIT: begin
          cnt_q   <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(MUL_STEPS - 1)) state_q <= S_DINIT;
        end
        S_DINIT: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_q <= S_UPDATE;
        end
        S_UPDATE: state_q <= S_CHECK;
        S_CHECK: state_q <= status_i.stop ? S_CINIT : S_SQUARE;
        S_CINIT: begin
          cnt_q   <= '0;
          state_q <= S_COR;
        end
        S_COR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(COR_STEPS - 1)) state_q <= S_ROUND;
        end
        S_ROUND: state_q <= S_FIN;
        S_FIN: begin
          if (slot_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/gcps_dp.sv */
// Datapath of the pitch solver: drop multiply/divide, aim update, CORDIC, result word.
// Depends on gcps_pkg; driven by gcps_ctrl.
module gcps_dp import gcps_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  cfg_t                       cfg_i,
  input  cmd_t                       cmd_i,
  output status_t                    status_o,
  input  logic [DIST_W-1:0]          distance_mm_i,
  input  logic signed [HEIGHT_W-1:0] height_mm_i,
  input  logic [SPEED_W-1:0]         speed_mm_s_i,
  output logic signed [PITCH_W-1:0]  pitch_angle_o,
  output logic [ITER_W-1:0]          iterations_used_o,
  output logic                       converged_o
);

  localparam int SH = 30 - ANGLE_FRAC_BITS;

  logic [DIST_W-1:0]          d_q;
  logic signed [HEIGHT_W-1:0] h_q;
  logic [32:0]                den_q;
  logic [29:0]                dd_q;
  logic signed [AIM_W-1:0]    y_q, last_y_q;
  logic [47:0]                ysq_q;
  logic [48:0]                mc_q;
  logic [62:0]                acc_q;
  logic [32:0]                rem_q;
  logic [DIV_STEPS-1:0]       nlo_q, q_q;
  logic [ITER_W-1:0]          passes_q;
  logic                       conv_q, stop_q;
  logic signed [COR_W-1:0]    x_q, w_q;
  logic signed [ANG_W-1:0]    z_q;
  logic signed [PITCH_W-1:0]  pitch_q;
  logic signed [PITCH_W-1:0]  pitch_out_q;
  logic [ITER_W-1:0]          iter_out_q;
  logic                       conv_out_q;

  logic [DIST_W-1:0]       d_cl;
  logic [SPEED_W-1:0]      v_cl;
  logic [AIM_W-1:0]        ay;
  logic [63:0]             n_full;
  logic [33:0]             r2;
  logic                    qbit;
  logic signed [45:0]      target, dy, ady;
  logic signed [AIM_W-1:0] y_sat;
  logic [ITER_W-1:0]       passes_inc;
  logic                    conv_now;
  logic signed [COR_W-1:0] xs, ws;
  logic signed [ANG_W-1:0] ang;
  logic signed [ANG_W:0]   z_rnd, z_sh;

  assign d_cl   = (distance_mm_i < DIST_MIN) ? DIST_MIN : distance_mm_i;
  assign v_cl   = (speed_mm_s_i < SPEED_MIN) ? SPEED_MIN : speed_mm_s_i;
  assign ay     = y_q[AIM_W-1] ? AIM_W'(-y_q) : AIM_W'(y_q);
  assign n_full = {1'b0, acc_q} + {32'd0, den_q[32:1]};
  assign r2     = {rem_q, nlo_q[DIV_STEPS-1]};
  assign qbit   = (r2 >= {1'b0, den_q});

  assign target     = 46'(h_q) + signed'({2'b00, q_q});
  assign dy         = target - 46'(y_q);
  assign ady        = dy[45] ? -dy : dy;
  assign conv_now   = (ady < signed'(46'(cfg_i.tolerance)));
  assign passes_inc = passes_q + 1'b1;
  always_comb begin
    if (target > 46'(AIM_LIMIT))       y_sat = AIM_LIMIT;
    else if (target < -46'(AIM_LIMIT)) y_sat = -AIM_LIMIT;
    else                               y_sat = target[AIM_W-1:0];
  end

  assign xs    = x_q >>> cmd_i.idx[4:0];
  assign ws    = w_q >>> cmd_i.idx[4:0];
  assign ang   = atan_q30(cmd_i.idx[4:0]);
  assign z_rnd = (ANG_W+1)'(z_q) + ((ANG_W+1)'(1) <<< (SH - 1));
  assign z_sh  = z_rnd >>> SH;

  assign status_o.stop       = stop_q;
  assign status_o.zero_limit = (cfg_i.max_iter == '0);

  assign pitch_angle_o     = pitch_out_q;
  assign iterations_used_o = iter_out_q;
  assign converged_o       = conv_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      d_q      <= d_cl;
      h_q      <= height_mm_i;
      y_q      <= AIM_W'(height_mm_i);
      dd_q     <= 30'(d_cl) * 30'(d_cl);
      den_q    <= {32'(v_cl) * 32'(v_cl), 1'b0};
      passes_q <= '0;
      conv_q   <= 1'b0;
      stop_q   <= 1'b0;
      pitch_q  <= '0;
    end
    if (cmd_i.square) ysq_q <= 48'(ay[23:0]) * 48'(ay[23:0]);
    if (cmd_i.mul_init) begin
      mc_q  <= 49'(dd_q) + 49'(ysq_q);
      acc_q <= '0;
    end
    if (cmd_i.mul_step && cfg_i.gravity[cmd_i.idx[3:0]])
      acc_q <= acc_q + (63'(mc_q) << cmd_i.idx[3:0]);
    if (cmd_i.div_init) begin
      rem_q <= 33'(n_full[63:DIV_STEPS]);
      nlo_q <= n_full[DIV_STEPS-1:0];
      q_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= qbit ? 33'(r2 - {1'b0, den_q}) : r2[32:0];
      nlo_q <= {nlo_q[DIV_STEPS-2:0], 1'b0};
      q_q   <= {q_q[DIV_STEPS-2:0], qbit};
    end
    if (cmd_i.update) begin
      last_y_q <= y_q;
      y_q      <= y_sat;
      passes_q <= passes_inc;
      conv_q   <= conv_now;
      stop_q   <= conv_now || (passes_inc == cfg_i.max_iter);
    end
    if (cmd_i.cor_init) begin
      x_q <= COR_W'(d_q) <<< COR_PRESHIFT;
      w_q <= COR_W'(last_y_q) <<< COR_PRESHIFT;
      z_q <= '0;
    end
    if (cmd_i.cor_step) begin
      if (!w_q[COR_W-1]) begin
        x_q <= x_q + ws;
        w_q <= w_q - xs;
        z_q <= z_q + ang;
      end else begin
        x_q <= x_q - ws;
        w_q <= w_q + xs;
        z_q <= z_q - ang;
      end
    end
    if (cmd_i.round) pitch_q <= z_sh[PITCH_W-1:0];
    if (cmd_i.emit) begin
      pitch_out_q <= pitch_q;
      iter_out_q  <= passes_q;
      conv_out_q  <= conv_q;
    end
  end

endmodule

/* hdl/gravity_compensated_pitch_solver_top.sv */
// Gravity compensated launch pitch solver, top level.
// Depends on gcps_pkg, gcps_in_if, gcps_out_if, gcps_ctrl and gcps_dp.
//
// A request word (distance_mm, height_mm, speed_mm_s) is taken on in_i when
// valid and ready are both high; ready is high only while no request is in
// work. One result word (pitch_angle, iterations_used, converged) leaves on
// out_o for each request.
// Each correction pass runs one square, a shift-add gravity multiply, a
// restoring divider for the drop and the aim update. After the last pass a
// 30-step CORDIC and a rounding step form the pitch. With a pass limit of 0
// the sequencer skips the passes and the CORDIC and goes straight to the result.
// A new request is taken only once the last one has left the sequencer.
// The result sits in an output register; a new request is accepted while it
// waits, and a finished request holds in the sequencer until that register
// frees up. Configuration writes on cfg_we_i are meant for idle time only.
// Reset returns the registers to gravity 9789, tolerance 10, pass limit 10
// and empties the block.
module gravity_compensated_pitch_solver_top import gcps_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  gcps_in_if.sink              in_i,
  gcps_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gravity   <= GRAVITY_RST;
      cfg_q.tolerance <= TOLERANCE_RST;
      cfg_q.max_iter  <= MAX_ITER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRAVITY:   cfg_q.gravity   <= cfg_data_i[GRAV_W-1:0];
        CFG_TOLERANCE: cfg_q.tolerance <= cfg_data_i[TOL_W-1:0];
        CFG_MAX_ITER:  cfg_q.max_iter  <= cfg_data_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  gcps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gcps_dp #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .cfg_i             (cfg_q),
    .cmd_i             (cmd),
    .status_o          (status),
    .distance_mm_i     (in_i.distance_mm),
    .height_mm_i       (in_i.height_mm),
    .speed_mm_s_i      (in_i.speed_mm_s),
    .pitch_angle_o     (out_o.pitch_angle),
    .iterations_used_o (out_o.iterations_used),
    .converged_o       (out_o.converged)
  );

endmodule
